[rtl/ursel_pkg.sv]
// Shared types and constants for the unchoke top-rate selector.
package ursel_pkg;

    localparam int PEER_ID_W = 8;
    localparam int RATE_W    = 32;
    localparam int ACT_W     = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [RATE_W-1:0] UP_LIMIT_RST   = RATE_W'(50 * 1024);
    // 103 gives the same test as "below 102.4" on integer rates
    localparam logic [RATE_W-1:0] DOWN_FLOOR_RST = RATE_W'(103);

    localparam logic [CFG_IDX_W-1:0] REG_UP_LIMIT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_FLOOR = 1'b1;

    typedef enum logic [ACT_W-1:0] {
        ACT_UNCHOKE = 2'd0,
        ACT_CHOKE   = 2'd1,
        ACT_NONE    = 2'd2
    } action_t;

    // Broadcast control from the sequencer to every slot cell
    typedef struct packed {
        logic upd;   // commit the current report this cycle
        logic take;  // report is eligible and not force-choked
        logic full;  // every slot holds a member
        logic ge;    // report rate >= minimum slot rate
        logic roll;  // chosen set becomes previous set, chosen set cleared
    } ursel_ctrl_t;

endpackage

[rtl/ursel_ifs.sv]
// Channel interfaces: peer report input and decision output.
interface ursel_in_if import ursel_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [PEER_ID_W-1:0] peer_id;
    logic [RATE_W-1:0]    dl_rate;
    logic [RATE_W-1:0]    up_rate;
    logic                 eligible;
    logic                 last_peer;

    modport source (output valid, peer_id, dl_rate, up_rate, eligible, last_peer,
                    input ready);
    modport sink   (input valid, peer_id, dl_rate, up_rate, eligible, last_peer,
                    output ready);
endinterface

interface ursel_out_if import ursel_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [PEER_ID_W-1:0] target_id;
    logic [ACT_W-1:0]     action;
    logic                 last_result;

    modport source (output valid, target_id, action, last_result, input ready);
    modport sink   (input valid, target_id, action, last_result, output ready);
endinterface

[rtl/ursel_cell.sv]
// One slot cell: chosen and previous member, plus one stage of the minimum chain.
module ursel_cell import ursel_pkg::*;
#(
    parameter int K    = 0,
    parameter int IDXW = 2,
    parameter int ID_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ursel_ctrl_t       ctrl,
    input  logic [ID_W-1:0]   new_id,
    input  logic [RATE_W-1:0] new_rate,
    input  logic [IDXW-1:0]   sel_idx,
    input  logic              left_valid,
    input  logic [RATE_W-1:0] left_min_rate,
    input  logic [IDXW-1:0]   left_min_idx,
    output logic              chosen_valid,
    output logic [ID_W-1:0]   chosen_id,
    output logic              prev_valid,
    output logic [ID_W-1:0]   prev_id,
    output logic [RATE_W-1:0] min_rate,
    output logic [IDXW-1:0]   min_idx
);

    localparam logic [IDXW-1:0] MY_IDX = IDXW'(K);

    logic              valid_reg;
    logic [ID_W-1:0]   id_reg;
    logic [RATE_W-1:0] rate_reg;
    logic              pvalid_reg;
    logic [ID_W-1:0]   pid_reg;
    logic [RATE_W-1:0] min_rate_reg;
    logic [IDXW-1:0]   min_idx_reg;
    logic [RATE_W-1:0] min_rate_next;
    logic [IDXW-1:0]   min_idx_next;
    logic              append;
    logic              replace;
    logic              wr;

    // first free slot takes the append; the first minimum slot takes a replace
    assign append  = ctrl.take & ~ctrl.full & ~valid_reg & left_valid;
    assign replace = ctrl.take & ctrl.full & ctrl.ge & (sel_idx == MY_IDX);
    assign wr      = ctrl.upd & (append | replace);

    // strict less keeps the earlier slot on ties
    always_comb
    begin
        if (K == 0 || rate_reg < left_min_rate)
        begin
            min_rate_next = rate_reg;
            min_idx_next  = MY_IDX;
        end
        else
        begin
            min_rate_next = left_min_rate;
            min_idx_next  = left_min_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            pvalid_reg <= 1'b0;
        end
        else if (ctrl.roll)
        begin
            pvalid_reg <= valid_reg;
            valid_reg  <= 1'b0;
        end
        else if (wr)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        min_rate_reg <= min_rate_next;
        min_idx_reg  <= min_idx_next;
        if (ctrl.roll)
        begin
            pid_reg <= id_reg;
        end
        if (wr)
        begin
            id_reg   <= new_id;
            rate_reg <= new_rate;
        end
    end

    assign chosen_valid = valid_reg;
    assign chosen_id    = id_reg;
    assign prev_valid   = pvalid_reg;
    assign prev_id      = pid_reg;
    assign min_rate     = min_rate_reg;
    assign min_idx      = min_idx_reg;

endmodule

[rtl/unchoke_top_rate_selector_unit.sv]
// Flow: a report beat is followed by the min-chain scan state and the update state.
// The last report of a round adds a diff state, which loads the 2*SLOTS-entry decision queue;
// empty entries ahead of the first decision are shifted out before it loads the output register.
// A new report is taken only in the idle state, after the previous one and any decision drain.
// Decisions leave from an output register; a stalled sink holds the queue drain and report input.
// Reset: asynchronous, active low; empty chosen and previous sets, registers at default values.
module unchoke_top_rate_selector_unit import ursel_pkg::*;
#(
    parameter int SLOTS   = 4,
    parameter int ID_BITS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RATE_W-1:0]    cfg_data,
    ursel_in_if.sink             report,
    ursel_out_if.source          decision
);

    // stored id width: peer_id carries at most PEER_ID_W bits
    localparam int IDW  = (ID_BITS < PEER_ID_W) ? ID_BITS : PEER_ID_W;
    localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int QN   = 2 * SLOTS;
    localparam logic [IDXW-1:0] SCAN_LAST = IDXW'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_DIFF,
        S_EMIT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [RATE_W-1:0] up_limit_reg;
    logic [RATE_W-1:0] down_floor_reg;

    // captured report
    logic [IDW-1:0]    id_reg;
    logic [RATE_W-1:0] down_reg;
    logic [RATE_W-1:0] up_reg;
    logic              elig_reg;
    logic              last_reg;
    logic [IDXW-1:0]   cnt_reg;

    // decision queue: a shift line drained from entry 0
    logic [IDW-1:0]    q_id_reg  [QN];
    action_t           q_act_reg [QN];
    logic [QN-1:0]     q_pend_reg;

    // output register
    logic                 out_valid_reg;
    logic [PEER_ID_W-1:0] out_id_reg;
    action_t              out_act_reg;
    logic                 out_last_reg;

    // cell row
    logic [SLOTS-1:0]             ch_valid;
    logic [SLOTS-1:0][IDW-1:0]    ch_id;
    logic [SLOTS-1:0]             pv_valid;
    logic [SLOTS-1:0][IDW-1:0]    pv_id;
    logic [SLOTS-1:0][RATE_W-1:0] mn_rate;
    logic [SLOTS-1:0][IDXW-1:0]   mn_idx;

    ursel_ctrl_t      ctrl_next;
    logic             prev_hit;
    logic             forced;
    logic [SLOTS-1:0] unch_flag;
    logic [SLOTS-1:0] choke_flag;
    logic             diff_none;
    logic             out_free;
    logic             emit_load;

    // ---------------------------------------------------------------
    // Configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_limit_reg   <= UP_LIMIT_RST;
            down_floor_reg <= DOWN_FLOOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_UP_LIMIT:   up_limit_reg   <= cfg_data;
                REG_DOWN_FLOOR: down_floor_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Slot cells. Each cell holds one chosen and one previous member;
    // the running minimum moves one cell to the right per cycle, so the
    // last cell holds the first minimum by the time the scan state ends.
    // ---------------------------------------------------------------
    for (genvar k = 0; k < SLOTS; k++)
    begin : g_cell
        logic              lv;
        logic [RATE_W-1:0] lrate;
        logic [IDXW-1:0]   lidx;

        if (k == 0)
        begin : g_head
            assign lv    = 1'b1;
            assign lrate = '0;
            assign lidx  = '0;
        end
        else
        begin : g_body
            assign lv    = ch_valid[k-1];
            assign lrate = mn_rate[k-1];
            assign lidx  = mn_idx[k-1];
        end

        ursel_cell #(
            .K    (k),
            .IDXW (IDXW),
            .ID_W (IDW)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl_next),
            .new_id        (id_reg),
            .new_rate      (down_reg),
            .sel_idx       (mn_idx[SLOTS-1]),
            .left_valid    (lv),
            .left_min_rate (lrate),
            .left_min_idx  (lidx),
            .chosen_valid  (ch_valid[k]),
            .chosen_id     (ch_id[k]),
            .prev_valid    (pv_valid[k]),
            .prev_id       (pv_id[k]),
            .min_rate      (mn_rate[k]),
            .min_idx       (mn_idx[k])
        );
    end

    // ---------------------------------------------------------------
    // Force-choke test: prior member uploading too much for too little
    // ---------------------------------------------------------------
    always_comb
    begin
        prev_hit = 1'b0;
        for (int j = 0; j < SLOTS; j++)
        begin
            if (pv_valid[j] && pv_id[j] == id_reg)
            begin
                prev_hit = 1'b1;
            end
        end
    end

    assign forced = prev_hit & (up_reg > up_limit_reg) & (down_reg < down_floor_reg);

    always_comb
    begin
        ctrl_next.upd  = (state_reg == S_UPDATE);
        ctrl_next.take = elig_reg & ~forced;
        ctrl_next.full = ch_valid[SLOTS-1];
        ctrl_next.ge   = (down_reg >= mn_rate[SLOTS-1]);
        ctrl_next.roll = (state_reg == S_DIFF);
    end

    // ---------------------------------------------------------------
    // Membership diff between chosen and previous sets
    // ---------------------------------------------------------------
    always_comb
    begin
        for (int k = 0; k < SLOTS; k++)
        begin
            unch_flag[k]  = ch_valid[k];
            choke_flag[k] = pv_valid[k];
            for (int j = 0; j < SLOTS; j++)
            begin
                if (pv_valid[j] && pv_id[j] == ch_id[k])
                begin
                    unch_flag[k] = 1'b0;
                end
                if (ch_valid[j] && ch_id[j] == pv_id[k])
                begin
                    choke_flag[k] = 1'b0;
                end
            end
        end
    end

    assign diff_none = ~(|{choke_flag, unch_flag});

    // ---------------------------------------------------------------
    // Sequencer, decision queue and output register
    // ---------------------------------------------------------------
    assign out_free  = ~out_valid_reg | decision.ready;
    assign emit_load = (state_reg == S_EMIT) & q_pend_reg[0] & out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            q_pend_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= emit_load;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (report.valid)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == SCAN_LAST)
                    begin
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    state_reg <= last_reg ? S_DIFF : S_IDLE;
                end
                S_DIFF:
                begin
                    // empty diff: one no-change beat
                    q_pend_reg <= diff_none ? QN'(1) : {choke_flag, unch_flag};
                    state_reg  <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!(|q_pend_reg))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (!q_pend_reg[0] || out_free)
                    begin
                        q_pend_reg <= q_pend_reg >> 1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && report.valid)
        begin
            id_reg   <= report.peer_id[IDW-1:0];
            down_reg <= report.dl_rate;
            up_reg   <= report.up_rate;
            elig_reg <= report.eligible;
            last_reg <= report.last_peer;
        end

        if (state_reg == S_DIFF)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                if (k == 0 && diff_none)
                begin
                    q_id_reg[k]  <= '0;
                    q_act_reg[k] <= ACT_NONE;
                end
                else
                begin
                    q_id_reg[k]  <= ch_id[k];
                    q_act_reg[k] <= ACT_UNCHOKE;
                end
                q_id_reg[SLOTS + k]  <= pv_id[k];
                q_act_reg[SLOTS + k] <= ACT_CHOKE;
            end
        end
        else if (state_reg == S_EMIT && (!q_pend_reg[0] || out_free))
        begin
            for (int i = 0; i < QN - 1; i++)
            begin
                q_id_reg[i]  <= q_id_reg[i+1];
                q_act_reg[i] <= q_act_reg[i+1];
            end
        end

        if (emit_load)
        begin
            out_id_reg   <= PEER_ID_W'(q_id_reg[0]);
            out_act_reg  <= q_act_reg[0];
            out_last_reg <= ~(|q_pend_reg[QN-1:1]);
        end
    end

    assign report.ready         = (state_reg == S_IDLE);
    assign decision.valid       = out_valid_reg;
    assign decision.target_id   = out_id_reg;
    assign decision.action      = out_act_reg;
    assign decision.last_result = out_last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // members fill slots from slot 0 without gaps
    a_chosen_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (ch_valid & (ch_valid + SLOTS'(1))) == '0)
        else $error("chosen slots not contiguous");

    a_prev_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (pv_valid & (pv_valid + SLOTS'(1))) == '0)
        else $error("previous slots not contiguous");

    // no new report while decisions of the round are still queued
    a_ready_queue_empty: assert property (@(posedge clk) disable iff (!rst_n)
        report.ready |-> !(|q_pend_reg))
        else $error("report taken with decisions pending");

    // closing a round always yields at least one decision
    a_diff_yields_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIFF) |=> (|q_pend_reg))
        else $error("round closed without a decision");

    // the chosen set becomes the previous set and is cleared when a round closes
    a_roll_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIFF) |=> (ch_valid == '0) && (pv_valid == $past(ch_valid)))
        else $error("set roll-over wrong");

endmodule

[tb/ursel_decision_checker.sv]
// Decision checker: predicts the unchoke/choke decisions from observed reports and compares.
module ursel_decision_checker import ursel_pkg::*;
#(
    parameter int SLOTS = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RATE_W-1:0]    cfg_data,
    ursel_in_if                  peer_mon,
    ursel_out_if                 dec_mon,
    output int                   owed,
    output int                   errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [PEER_ID_W-1:0] target;
        action_t              act;
        logic                 last;
    } decision_t;

    logic [RATE_W-1:0]    up_limit;
    logic [RATE_W-1:0]    down_floor;
    logic [PEER_ID_W-1:0] pick_ids   [SLOTS];
    logic [RATE_W-1:0]    pick_rates [SLOTS];
    int                   pick_cnt;
    logic [PEER_ID_W-1:0] prior_ids  [SLOTS];
    int                   prior_cnt;
    decision_t            owed_q [$];
    int                   err_tally;

    function automatic bit holds_id(input logic [PEER_ID_W-1:0] ids [SLOTS], input int cnt,
                                    input logic [PEER_ID_W-1:0] id);
        for (int k = 0; k < cnt && k < SLOTS; k++)
            if (ids[k] == id)
                return 1'b1;
        return 1'b0;
    endfunction

    // One report beat: update the chosen set, and on the last report close the round
    function automatic void absorb_report(input logic [PEER_ID_W-1:0] id,
                                          input logic [RATE_W-1:0] down,
                                          input logic [RATE_W-1:0] up,
                                          input logic elig, input logic last);
        bit        forced;
        int        mi;
        int        nb;
        decision_t batch [2*SLOTS];
        forced = holds_id(prior_ids, prior_cnt, id) && (up > up_limit) && (down < down_floor);
        if (elig && !forced) begin
            if (pick_cnt < SLOTS) begin
                pick_ids[pick_cnt]   = id;
                pick_rates[pick_cnt] = down;
                pick_cnt++;
            end
            else begin
                // first slot holding the minimum wins ties
                mi = 0;
                for (int k = 1; k < SLOTS; k++)
                    if (pick_rates[k] < pick_rates[mi])
                        mi = k;
                if (down >= pick_rates[mi]) begin
                    pick_ids[mi]   = id;
                    pick_rates[mi] = down;
                end
            end
        end
        if (!last)
            return;
        nb = 0;
        for (int k = 0; k < pick_cnt; k++)
            if (!holds_id(prior_ids, prior_cnt, pick_ids[k])) begin
                batch[nb] = '{target: pick_ids[k], act: ACT_UNCHOKE, last: 1'b0};
                nb++;
            end
        for (int k = 0; k < prior_cnt; k++)
            if (!holds_id(pick_ids, pick_cnt, prior_ids[k])) begin
                batch[nb] = '{target: prior_ids[k], act: ACT_CHOKE, last: 1'b0};
                nb++;
            end
        if (nb == 0) begin
            batch[0] = '{target: '0, act: ACT_NONE, last: 1'b0};
            nb = 1;
        end
        for (int j = 0; j < nb; j++) begin
            batch[j].last = (j == nb - 1);
            owed_q.push_back(batch[j]);
        end
        prior_ids = pick_ids;
        prior_cnt = pick_cnt;
        for (int k = 0; k < SLOTS; k++) begin
            pick_ids[k]   = '0;
            pick_rates[k] = '0;
        end
        pick_cnt = 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        decision_t want;
        if (!rst_n)
        begin
            up_limit   = UP_LIMIT_RST;
            down_floor = DOWN_FLOOR_RST;
            for (int k = 0; k < SLOTS; k++)
            begin
                pick_ids[k]   = '0;
                pick_rates[k] = '0;
                prior_ids[k]  = '0;
            end
            pick_cnt  = 0;
            prior_cnt = 0;
            owed_q.delete();
            err_tally = 0;
            owed   <= 0;
            errors <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_UP_LIMIT:   up_limit   = cfg_data;
                    REG_DOWN_FLOOR: down_floor = cfg_data;
                    default: ;
                endcase
            end
            if (dec_mon.valid && dec_mon.ready)
            begin
                if (owed_q.size() == 0)
                begin
                    $display("%0t: unexpected decision: expected none, got id %0d action %0d last %0b",
                             $time, dec_mon.target_id, dec_mon.action, dec_mon.last_result);
                    err_tally++;
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (dec_mon.target_id !== want.target)
                    begin
                        $display("%0t: target_id mismatch: expected %0d, got %0d",
                                 $time, want.target, dec_mon.target_id);
                        err_tally++;
                    end
                    if (dec_mon.action !== want.act)
                    begin
                        $display("%0t: action mismatch: expected %0d, got %0d",
                                 $time, want.act, dec_mon.action);
                        err_tally++;
                    end
                    if (dec_mon.last_result !== want.last)
                    begin
                        $display("%0t: last_result mismatch: expected %0b, got %0b",
                                 $time, want.last, dec_mon.last_result);
                        err_tally++;
                    end
                end
            end
            if (peer_mon.valid && peer_mon.ready)
                absorb_report(peer_mon.peer_id, peer_mon.dl_rate, peer_mon.up_rate,
                              peer_mon.eligible, peer_mon.last_peer);
            owed   <= owed_q.size();
            errors <= err_tally;
        end
    end

endmodule

[tb/tb_unchoke_top_rate_selector_unit.sv]
// Testbench top: drives peer-report rounds and thresholds into the selector and gives the verdict.
module tb_unchoke_top_rate_selector_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import ursel_pkg::*;

    localparam int SLOTS = 4;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [RATE_W-1:0]    cfg_data;
    int                   owed;
    int                   errors;

    // shadow of the thresholds last written, used only to aim rates at the boundaries
    logic [RATE_W-1:0]    cur_limit;
    logic [RATE_W-1:0]    cur_floor;
    int                   sent;
    bit                   no_idle;       // phase with back-to-back beats on both sides
    bit                   squeeze_req;   // ask the sink side for one long hold-off
    bit                   squeeze_done;

    ursel_in_if  peer_in ();
    ursel_out_if decision_out ();

    unchoke_top_rate_selector_unit #(
        .SLOTS   (SLOTS),
        .ID_BITS (PEER_ID_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .report    (peer_in),
        .decision  (decision_out)
    );

    ursel_decision_checker #(
        .SLOTS (SLOTS)
    ) chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .peer_mon  (peer_in),
        .dec_mon   (decision_out),
        .owed      (owed),
        .errors    (errors)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Hard stop: far beyond the slowest legal run (long gaps, long stalls, full decision bursts)
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Idle length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    // Ids come mostly from a small pool so prior members come back and get force-choked
    function automatic logic [PEER_ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return PEER_ID_W'($urandom_range(0, 9));
        if (r < 75)
            return '1;
        if (r < 80)
            return '0;
        return PEER_ID_W'($urandom_range(0, 255));
    endfunction

    // Download rates: extremes, around the floor, small values for ties, full random
    function automatic logic [RATE_W-1:0] pick_down();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return cur_floor - 1;
            3:       return cur_floor;
            4:       return cur_floor + 1;
            5, 6:    return RATE_W'($urandom_range(0, 15));
            7:       return RATE_W'($urandom_range(0, 200));
            default: return $urandom;
        endcase
    endfunction

    // Upload rates: extremes and both sides of the limit
    function automatic logic [RATE_W-1:0] pick_up();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return cur_limit;
            3:       return cur_limit + 1;
            4:       return RATE_W'($urandom_range(0, 100));
            default: return $urandom;
        endcase
    endfunction

    // One report beat; valid stays high across back-to-back beats
    task automatic offer_report(input logic [PEER_ID_W-1:0] id, input logic [RATE_W-1:0] down,
                                input logic [RATE_W-1:0] up, input logic elig,
                                input logic last);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            peer_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        peer_in.valid     <= 1'b1;
        peer_in.peer_id   <= id;
        peer_in.dl_rate   <= down;
        peer_in.up_rate   <= up;
        peer_in.eligible  <= elig;
        peer_in.last_peer <= last;
        do
            @(posedge clk);
        while (!peer_in.ready);
        sent++;
    endtask

    // Wait for every owed decision, then let the report pipeline run dry
    task automatic drain_decisions();
        peer_in.valid <= 1'b0;
        @(posedge clk);
        while (owed != 0)
            @(posedge clk);
        repeat (2 * SLOTS + 8) @(posedge clk);
    endtask

    // Both threshold registers, one write each; only called while the block is idle
    task automatic load_thresholds(input logic [RATE_W-1:0] limit, input logic [RATE_W-1:0] floor);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_UP_LIMIT;
        cfg_data  <= limit;
        @(posedge clk);
        cfg_index <= REG_DOWN_FLOOR;
        cfg_data  <= floor;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_limit = limit;
        cur_floor = floor;
    endtask

    // A random round: mostly eligible reports, closing with the last mark; some noise rounds
    task automatic random_round();
        int  n;
        int  r;
        bit  dead;
        r = $urandom_range(0, 99);
        if (r < 10)
            n = 1;
        else if (r < 80)
            n = $urandom_range(2, 6);
        else
            n = $urandom_range(7, 12);
        dead = ($urandom_range(0, 99) < 5);
        for (int k = 0; k < n; k++)
            offer_report(pick_id(), pick_down(), pick_up(),
                         !dead && ($urandom_range(0, 99) < 85), k == n - 1);
    endtask

    // Sink side: random hold-offs, a back-to-back mode, and one long squeeze on request
    initial
    begin : sink_side
        int hold;
        int open_len;
        decision_out.ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (squeeze_req && !squeeze_done)
            begin
                // long enough for the decision queue to fill and the report input to stall
                decision_out.ready <= 1'b0;
                repeat (400) @(posedge clk);
                squeeze_done = 1'b1;
            end
            else if (no_idle)
            begin
                decision_out.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                hold = pick_gap();
                if (hold > 0)
                begin
                    decision_out.ready <= 1'b0;
                    repeat (hold) @(posedge clk);
                end
                decision_out.ready <= 1'b1;
                open_len = $urandom_range(1, 8);
                repeat (open_len) @(posedge clk);
            end
        end
    end

    initial
    begin : source_side
        int start;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_UP_LIMIT;
        cfg_data          = '0;
        peer_in.valid     = 1'b0;
        peer_in.peer_id   = '0;
        peer_in.dl_rate   = '0;
        peer_in.up_rate   = '0;
        peer_in.eligible  = 1'b0;
        peer_in.last_peer = 1'b0;
        cur_limit         = UP_LIMIT_RST;
        cur_floor         = DOWN_FLOOR_RST;
        sent              = 0;
        no_idle           = 1'b0;
        squeeze_req       = 1'b0;
        squeeze_done      = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed rounds, reset thresholds ----
        // lone fastest peer, top id: unchoke
        offer_report(8'hFF, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1);
        // same peer returns as a freeloader: forced out, so it is choked
        offer_report(8'hFF, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b1);
        // only an ineligible report with id zero: empty round, no change
        offer_report(8'h00, 32'h5, 32'h5, 1'b0, 1'b1);
        // filling slots, a repeated id, a tie that replaces the first minimum, a loser
        offer_report(8'd1, 32'd10, 32'd0, 1'b1, 1'b0);
        offer_report(8'd2, 32'd20, 32'd0, 1'b1, 1'b0);
        offer_report(8'd3, 32'd10, 32'd0, 1'b1, 1'b0);
        offer_report(8'd3, 32'd30, 32'd0, 1'b1, 1'b0);
        offer_report(8'd9, 32'd7,  32'd0, 1'b0, 1'b0);
        offer_report(8'd5, 32'd10, 32'd0, 1'b1, 1'b0);
        offer_report(8'd6, 32'd5,  32'd0, 1'b1, 1'b1);
        // threshold edges: just past both is forced, limit itself or floor itself is not;
        // peer 3 appears twice in the prior set and both copies get choked
        offer_report(8'd3, DOWN_FLOOR_RST - 1, UP_LIMIT_RST + 1, 1'b1, 1'b0);
        offer_report(8'd5, 32'd0, UP_LIMIT_RST, 1'b1, 1'b0);
        offer_report(8'd2, DOWN_FLOOR_RST, 32'hFFFF_FFFF, 1'b1, 1'b1);
        drain_decisions();

        // strictest thresholds: any prior member with traffic out and not full rate in
        load_thresholds(32'h0, 32'hFFFF_FFFF);
        offer_report(8'd5, 32'd100, 32'd1, 1'b1, 1'b0);
        offer_report(8'd2, 32'hFFFF_FFFF, 32'd1, 1'b1, 1'b1);
        drain_decisions();

        // loosest thresholds: nothing is ever forced; a forced-looking last report is kept
        load_thresholds(32'hFFFF_FFFF, 32'h0);
        offer_report(8'd2, 32'd7, 32'hFFFF_FFFF, 1'b1, 1'b1);
        offer_report(8'hAA, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b0);
        offer_report(8'h55, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b1);
        drain_decisions();

        // ---- random phases, one threshold setting each ----
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    load_thresholds(UP_LIMIT_RST, DOWN_FLOOR_RST);
                    squeeze_req = 1'b1;
                end
                1:  load_thresholds(RATE_W'($urandom_range(0, 2000)),
                                    RATE_W'($urandom_range(0, 2000)));
                2:
                begin
                    load_thresholds(32'h0, 32'hFFFF_FFFF);
                    no_idle = 1'b1;
                end
                default:
                begin
                    load_thresholds($urandom, $urandom);
                    no_idle = 1'b0;
                end
            endcase
            start = sent;
            while (sent - start < 60)
                random_round();
            drain_decisions();
        end

        if (errors == 0 && owed == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
rtl/ursel_pkg.sv
rtl/ursel_ifs.sv
rtl/ursel_cell.sv
rtl/unchoke_top_rate_selector_unit.sv
tb/ursel_decision_checker.sv
tb/tb_unchoke_top_rate_selector_unit.sv
